>>> hw/rtl/pafa_pkg.sv
package pafa_pkg;

    localparam int MAX_STEP = 10486;
    localparam int DT_W = $clog2(MAX_STEP + 1);
    localparam int DIV_DIVIDEND_W = 52;
    localparam int DIV_COUNT_W = $clog2(DIV_DIVIDEND_W + 1);
    localparam int MAG_W = 61;
    localparam logic [63:0] TERM_CAP = 64'd1 << 60;
    localparam logic [16:0] TWIST_CEIL = 17'd32768;
    localparam int TINY_RAW = 7;

    localparam logic [2:0] REG_P_GAIN = 3'd0;
    localparam logic [2:0] REG_I_GAIN = 3'd1;
    localparam logic [2:0] REG_D_GAIN = 3'd2;
    localparam logic [2:0] REG_FF_GAIN = 3'd3;
    localparam logic [2:0] REG_WINDUP = 3'd4;
    localparam logic [2:0] REG_STIFFNESS = 3'd5;
    localparam logic [2:0] REG_INV_DAMPING = 3'd6;
    localparam logic [2:0] REG_MAX_TWIST = 3'd7;

    typedef enum logic [2:0] {
        OP_INT,
        OP_P,
        OP_FF,
        OP_R,
        OP_I,
        OP_D,
        OP_T,
        OP_X
    } op_t;

    typedef struct packed {
        logic take_in;
        logic pre;
        logic div_start;
        logic load;
        logic mlo;
        logic mhi;
        logic fin;
        logic drive;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_status_t;

endpackage

>>> hw/rtl/pafa_div.sv
module pafa_div
    import pafa_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DIV_DIVIDEND_W-1:0] dividend,
    input  logic [DT_W-1:0]           divisor,
    output logic                      busy,
    output logic [DIV_DIVIDEND_W-1:0] quotient
);

    logic [DT_W-1:0]           rem_reg, rem_next;
    logic [DIV_DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DT_W-1:0]           dsr_reg;
    logic [DIV_COUNT_W-1:0]    cnt_reg;
    logic                      busy_reg;
    logic [DT_W:0]             trial;

    always_comb begin
        trial = {rem_reg, quo_reg[DIV_DIVIDEND_W-1]};
        quo_next = {quo_reg[DIV_DIVIDEND_W-2:0], 1'b0};
        rem_next = trial[DT_W-1:0];
        if (trial >= {1'b0, dsr_reg}) begin
            rem_next = DT_W'(trial - {1'b0, dsr_reg});
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= DIV_COUNT_W'(DIV_DIVIDEND_W);
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_COUNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/pafa_dp.sv
module pafa_dp
    import pafa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic [87:0] in_data,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [55:0] out_data
);

    logic [31:0] kp_reg, ki_reg, kd_reg, ff_reg, stiff_reg, invd_reg;
    logic [30:0] windup_reg;
    logic [15:0] maxtw_reg;

    logic signed [31:0] meas_reg, tgt_reg, err_reg, prev_err_reg, prev_drive_reg, drive_reg;
    logic [19:0]        et_reg;
    logic [DT_W-1:0]    dt_reg;
    logic signed [47:0] integ_reg, disp_reg;
    logic signed [63:0] acc_reg, restore_reg;
    logic signed [16:0] twist_reg, twist_out_reg;
    logic signed [31:0] drive_out_reg;
    logic               diff_neg_reg;

    logic [MAG_W-1:0]   mag_reg;
    logic [31:0]        b_reg;
    logic [5:0]         sh_reg;
    logic               neg_reg;
    logic [63:0]        lo_reg, hi_reg;

    logic signed [32:0] raw_err, diff;
    logic [31:0]        diff_mag;
    logic [DIV_DIVIDEND_W-1:0] quo;
    logic               div_busy;
    logic signed [63:0] deriv;
    logic signed [63:0] a_sel;
    logic [31:0]        b_sel;
    logic               bneg_sel;
    logic [5:0]         sh_sel;
    logic [63:0]        a_mag;
    logic [5:0]         up;
    logic [63:0]        limit, shifted, r;
    logic signed [63:0] res, sum64, neg_res;
    logic [16:0]        cap;
    logic [32:0]        err_mag;
    logic signed [31:0] drive_sat;
    logic [31:0]        tw_mag, dr_mag;
    logic               reset_disp;

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sd140737488355327) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (v < -64'sd140737488355328) begin
            return 48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

    pafa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({diff_mag, 20'd0}),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign status.div_busy = div_busy;

    always_comb begin
        raw_err = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};
        diff = {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
        diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
        if (dt_reg == '0) begin
            deriv = '0;
        end else if (diff_neg_reg) begin
            deriv = -$signed({12'd0, quo});
        end else begin
            deriv = $signed({12'd0, quo});
        end
        err_mag = err_reg[31] ? 33'(-{err_reg[31], err_reg}) : {1'b0, err_reg};

        a_sel = '0;
        b_sel = '0;
        bneg_sel = 1'b0;
        sh_sel = 6'd16;
        case (cmd.op)
            OP_INT: begin
                a_sel = 64'(err_reg);
                b_sel = 32'(dt_reg);
                sh_sel = 6'd12;
            end
            OP_P: begin
                a_sel = 64'(err_reg);
                b_sel = kp_reg;
            end
            OP_FF: begin
                a_sel = 64'(tgt_reg);
                bneg_sel = ff_reg[31];
                b_sel = ff_reg[31] ? 32'(-ff_reg) : ff_reg;
            end
            OP_R: begin
                a_sel = 64'(disp_reg);
                b_sel = stiff_reg;
                sh_sel = 6'd32;
            end
            OP_I: begin
                a_sel = 64'(integ_reg);
                b_sel = ki_reg;
                sh_sel = 6'd24;
            end
            OP_D: begin
                a_sel = deriv;
                b_sel = kd_reg;
            end
            OP_T: begin
                a_sel = 64'(drive_reg) - restore_reg;
                b_sel = invd_reg;
            end
            OP_X: begin
                a_sel = 64'(twist_reg);
                b_sel = 32'(dt_reg);
                sh_sel = 6'd4;
            end
            default: begin
                a_sel = '0;
            end
        endcase
        a_mag = a_sel[63] ? 64'(-a_sel) : 64'(a_sel);

        up = 6'd32 - sh_reg;
        limit = TERM_CAP >> up;
        shifted = (hi_reg << up) + (lo_reg >> sh_reg);
        if (hi_reg > limit || shifted > TERM_CAP) begin
            r = TERM_CAP;
        end else begin
            r = shifted;
        end
        res = neg_reg ? -$signed(r) : $signed(r);
        neg_res = -res;

        cap = ({1'b0, maxtw_reg} > TWIST_CEIL) ? TWIST_CEIL : {1'b0, maxtw_reg};

        if (acc_reg > 64'sd2147483647) begin
            drive_sat = 32'sh7FFF_FFFF;
        end else if (acc_reg < -64'sd2147483648) begin
            drive_sat = 32'sh8000_0000;
        end else begin
            drive_sat = acc_reg[31:0];
        end

        sum64 = 64'(disp_reg) + res;
        tw_mag = twist_reg[16] ? 32'(-32'(twist_reg)) : 32'(twist_reg);
        dr_mag = drive_reg[31] ? 32'(-drive_reg) : drive_reg;
        reset_disp = (tw_mag < 32'(TINY_RAW)) || (dr_mag < 32'(TINY_RAW)) ||
                     (prev_drive_reg < 0 && drive_reg > 0) ||
                     (prev_drive_reg > 0 && drive_reg < 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= 32'd65536;
            ki_reg <= '0;
            kd_reg <= '0;
            ff_reg <= '0;
            windup_reg <= 31'h7FFF_FFFF;
            stiff_reg <= '0;
            invd_reg <= 32'd65536;
            maxtw_reg <= 16'd32768;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_P_GAIN:      kp_reg <= cfg_wdata;
                REG_I_GAIN:      ki_reg <= cfg_wdata;
                REG_D_GAIN:      kd_reg <= cfg_wdata;
                REG_FF_GAIN:     ff_reg <= cfg_wdata;
                REG_WINDUP:      windup_reg <= cfg_wdata[30:0];
                REG_STIFFNESS:   stiff_reg <= cfg_wdata;
                REG_INV_DAMPING: invd_reg <= cfg_wdata;
                REG_MAX_TWIST:   maxtw_reg <= cfg_wdata[15:0];
                default:         kp_reg <= kp_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            prev_err_reg <= '0;
            disp_reg <= '0;
            prev_drive_reg <= '0;
        end else begin
            if (cmd.drive) begin
                prev_err_reg <= err_reg;
            end
            if (cmd.fin && cmd.op == OP_INT && err_mag < {2'b0, windup_reg}) begin
                integ_reg <= sat48(64'(integ_reg) + res);
            end
            if (cmd.fin && cmd.op == OP_X) begin
                disp_reg <= reset_disp ? '0 : sat48(sum64);
                prev_drive_reg <= drive_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            meas_reg <= in_data[31:0];
            tgt_reg <= in_data[63:32];
            et_reg <= in_data[83:64];
        end
        if (cmd.pre) begin
            if (raw_err > 33'sd2147483647) begin
                err_reg <= 32'sh7FFF_FFFF;
            end else if (raw_err < -33'sd2147483648) begin
                err_reg <= 32'sh8000_0000;
            end else begin
                err_reg <= raw_err[31:0];
            end
            dt_reg <= (et_reg > 20'(MAX_STEP)) ? DT_W'(MAX_STEP) : et_reg[DT_W-1:0];
        end
        if (cmd.div_start) begin
            diff_neg_reg <= diff[32];
        end
        if (cmd.load) begin
            mag_reg <= a_mag[MAG_W-1:0];
            b_reg <= b_sel;
            sh_reg <= sh_sel;
            neg_reg <= a_sel[63] ^ bneg_sel;
        end
        if (cmd.mlo) begin
            lo_reg <= 64'(mag_reg[31:0]) * 64'(b_reg);
        end
        if (cmd.mhi) begin
            hi_reg <= 64'(mag_reg[MAG_W-1:32]) * 64'(b_reg);
        end
        if (cmd.fin) begin
            case (cmd.op)
                OP_P:    acc_reg <= res;
                OP_FF,
                OP_I,
                OP_D:    acc_reg <= acc_reg + res;
                OP_R:    restore_reg <= res;
                OP_T: begin
                    if (neg_res > $signed(64'(cap))) begin
                        twist_reg <= $signed(cap);
                    end else if (neg_res < -$signed(64'(cap))) begin
                        twist_reg <= -$signed(cap);
                    end else begin
                        twist_reg <= neg_res[16:0];
                    end
                end
                OP_X: begin
                    twist_out_reg <= twist_reg;
                    drive_out_reg <= drive_reg;
                end
                default: acc_reg <= acc_reg;
            endcase
        end
        if (cmd.drive) begin
            drive_reg <= drive_sat;
        end
    end

    assign out_data = {7'd0, drive_out_reg, twist_out_reg};

endmodule

>>> hw/rtl/pafa_ctrl.sv
module pafa_ctrl
    import pafa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_LOAD,
        S_MLO,
        S_MHI,
        S_FIN,
        S_WDIV,
        S_DRV,
        S_WOUT
    } state_t;

    state_t state_reg;
    op_t    op_reg;
    logic   m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg <= OP_INT;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_PRE;
                    end
                end
                S_PRE: begin
                    op_reg <= OP_INT;
                    state_reg <= S_LOAD;
                end
                S_LOAD: state_reg <= S_MLO;
                S_MLO:  state_reg <= S_MHI;
                S_MHI:  state_reg <= S_FIN;
                S_FIN: begin
                    case (op_reg)
                        OP_INT: begin
                            op_reg <= OP_P;
                            state_reg <= S_LOAD;
                        end
                        OP_P: begin
                            op_reg <= OP_FF;
                            state_reg <= S_LOAD;
                        end
                        OP_FF: begin
                            op_reg <= OP_R;
                            state_reg <= S_LOAD;
                        end
                        OP_R: begin
                            op_reg <= OP_I;
                            state_reg <= S_LOAD;
                        end
                        OP_I: begin
                            op_reg <= OP_D;
                            state_reg <= S_WDIV;
                        end
                        OP_D: begin
                            op_reg <= OP_T;
                            state_reg <= S_DRV;
                        end
                        OP_T: begin
                            op_reg <= OP_X;
                            state_reg <= S_WOUT;
                        end
                        OP_X: begin
                            m_tvalid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_WDIV: begin
                    if (!status.div_busy) begin
                        state_reg <= S_LOAD;
                    end
                end
                S_DRV: state_reg <= S_LOAD;
                S_WOUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.take_in = (state_reg == S_IDLE) && s_tvalid;
        cmd.pre = (state_reg == S_PRE);
        cmd.div_start = (state_reg == S_LOAD) && (op_reg == OP_INT);
        cmd.load = (state_reg == S_LOAD);
        cmd.mlo = (state_reg == S_MLO);
        cmd.mhi = (state_reg == S_MHI);
        cmd.fin = (state_reg == S_FIN);
        cmd.drive = (state_reg == S_DRV);
        cmd.op = op_reg;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> hw/rtl/pid_admittance_force_axis_unit.sv
// Each input transfer passes through the 52-step serial divider for the derivative
// and eight products on one shared multiplier before its result is presented.
// A new input is taken only once the previous result is presented; the next input
// is taken while a result waits, and its last product waits for that output transfer.
// Reset: synchronous, active low; clears the controller, the integral, the displacement,
// the previous error and drive, and returns the configuration registers to their reset values.
module pid_admittance_force_axis_unit
    import pafa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: measured[31:0], target[63:32], elapsed[83:64].
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: twist_command[16:0], drive_value[48:17].
    output logic [55:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pafa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pafa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );

endmodule

>>> bench/tb_pid_admittance_force_axis_unit.sv
`timescale 1ns / 1ps

module tb_pid_admittance_force_axis_unit;
    import pafa_pkg::*;

    localparam longint TERM_LIM = 64'sd1 << 60;
    localparam longint SAT48_HI = (64'sd1 <<< 47) - 1;
    localparam longint SAT48_LO = -(64'sd1 <<< 47);
    localparam longint I32_HI = 64'sd2147483647;
    localparam longint I32_LO = -64'sd2147483648;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [19:0] elapsed;
        logic [31:0] target;
        logic [31:0] measured;
    } sample_t;

    typedef struct packed {
        logic [31:0] drive;
        logic [16:0] twist;
    } command_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    pid_admittance_force_axis_unit DUT (.*);

    // Model copy of the registers and state.
    logic [31:0] kp, ki, kd, kff, stiff, inv_damp;
    logic [30:0] windup;
    logic [15:0] twist_cap;
    longint      integ = '0;
    longint      disp = '0;
    int          prev_err = 0;
    int          prev_drive = 0;

    sample_t     pending_samples[$];
    command_t    expected_commands[$];
    int          failures = 0;
    int          idle_cycles;
    int          in_wait, out_wait;
    bit          feeding;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Product of a magnitude and a 32-bit operand, shifted and capped.
    function automatic longint umul_shr(longint m, longint b, int sh);
        logic [127:0] p;
        p = 128'(m) * 128'(b);
        p = p >> sh;
        return p > 128'(TERM_LIM) ? TERM_LIM : longint'(p[63:0]);
    endfunction

    function automatic longint smul_shr(longint a, longint b, int sh);
        longint r;
        r = umul_shr(mag(a), mag(b), sh);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic command_t step_controller(sample_t s);
        longint meas, tgt, dt, err, deriv, sum, drv, rest, tw, cap;
        command_t c;
        meas = longint'(signed'(s.measured));
        tgt = longint'(signed'(s.target));
        dt = s.elapsed > 20'(MAX_STEP) ? longint'(MAX_STEP) : longint'(s.elapsed);
        err = clamp(tgt - meas, I32_LO, I32_HI);
        if (mag(err) < longint'(windup))
            integ = clamp(integ + smul_shr(err, dt, 12), SAT48_LO, SAT48_HI);
        deriv = '0;
        if (dt != 0)
            deriv = ((err - longint'(prev_err)) * (64'sd1 << 20)) / dt;
        sum = smul_shr(err, longint'(kp), 16) + smul_shr(integ, longint'(ki), 24)
            + smul_shr(deriv, longint'(kd), 16)
            + smul_shr(tgt, longint'(signed'(kff)), 16);
        drv = clamp(sum, I32_LO, I32_HI);
        prev_err = int'(err);
        rest = smul_shr(disp, longint'(stiff), 32);
        tw = -smul_shr(drv - rest, longint'(inv_damp), 16);
        cap = twist_cap > 16'd32768 ? longint'(32768) : longint'(twist_cap);
        tw = clamp(tw, -cap, cap);
        disp = clamp(disp + smul_shr(tw, dt, 4), SAT48_LO, SAT48_HI);
        if (mag(tw) < TINY_RAW || mag(drv) < TINY_RAW || (prev_drive < 0 && drv > 0)
                || (prev_drive > 0 && drv < 0))
            disp = '0;
        prev_drive = int'(drv);
        c.twist = tw[16:0];
        c.drive = drv[31:0];
        return c;
    endfunction

    task automatic add_sample(input sample_t smp);
        pending_samples = {pending_samples, smp};
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_wait <= 0;
        end else if (s_tvalid && !s_tready) begin
        end else if (in_wait > 0) begin
            s_tvalid <= 1'b0;
            in_wait <= in_wait - 1;
        end else if (pending_samples.size() > 0 && feeding) begin
            sample_t s;
            s = pending_samples[0];
            pending_samples.delete(0);
            s_tdata <= {4'd0, s};
            s_tvalid <= 1'b1;
            expected_commands = {expected_commands, step_controller(s)};
            in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_wait <= 0;
            idle_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                command_t got, exp_c;
                got = m_tdata[48:0];
                if (expected_commands.size() == 0) begin
                    $error("unexpected transfer twist=%0h drive=%0h", got.twist, got.drive);
                    failures++;
                end else begin
                    exp_c = expected_commands[0];
                    expected_commands.delete(0);
                    if (got.twist !== exp_c.twist) begin
                        $error("twist_command expected %0h got %0h", exp_c.twist, got.twist);
                        failures++;
                    end
                    if (got.drive !== exp_c.drive) begin
                        $error("drive_value expected %0h got %0h", exp_c.drive, got.drive);
                        failures++;
                    end
                end
                out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else if (out_wait > 0) begin
                out_wait <= out_wait - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && idle_cycles >= STALL_LIMIT) begin
            $display("pid_admittance_force_axis_unit: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_P_GAIN:      kp = val;
            REG_I_GAIN:      ki = val;
            REG_D_GAIN:      kd = val;
            REG_FF_GAIN:     kff = val;
            REG_WINDUP:      windup = val[30:0];
            REG_STIFFNESS:   stiff = val;
            REG_INV_DAMPING: inv_damp = val;
            REG_MAX_TWIST:   twist_cap = val[15:0];
            default: ;
        endcase
    endtask

    task automatic run_samples();
        feeding = 1'b1;
        wait (pending_samples.size() == 0);
        @(posedge aclk);
        while (s_tvalid || expected_commands.size() > 0)
            @(posedge aclk);
        feeding = 1'b0;
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_force();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 20)) - 10);
            default: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        s.measured = rand_force();
        s.target = rand_force();
        case ($urandom_range(0, 5))
            0: s.elapsed = 20'($urandom());
            1: s.elapsed = 0;
            default: s.elapsed = 20'($urandom_range(1, 2 * MAX_STEP));
        endcase
        return s;
    endfunction

    task automatic random_config();
        write_reg(REG_P_GAIN, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 18));
        write_reg(REG_I_GAIN, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 17));
        write_reg(REG_D_GAIN, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 10));
        write_reg(REG_FF_GAIN, $urandom_range(0, 3) == 0 ? $urandom()
                               : 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17));
        write_reg(REG_WINDUP, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 22));
        write_reg(REG_STIFFNESS, $urandom_range(0, 2) == 0 ? $urandom()
                                 : $urandom_range(0, 1 << 20));
        write_reg(REG_INV_DAMPING, $urandom_range(0, 2) == 0 ? $urandom()
                                   : $urandom_range(0, 1 << 18));
        write_reg(REG_MAX_TWIST, $urandom_range(0, 3) == 0 ? $urandom()
                                 : $urandom_range(65, 32768));
    endtask

    initial begin
        sample_t s;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_P_GAIN;
        cfg_wdata = '0;
        feeding = 1'b0;
        kp = 32'd65536; ki = 0; kd = 0; kff = 0;
        windup = 31'h7FFFFFFF; stiff = 0; inv_damp = 32'd65536; twist_cap = 16'd32768;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, zero time, error overflow, sign changes.
        add_sample('{20'd100, 32'h7FFFFFFF, 32'h80000000});
        add_sample('{20'd0, 32'h80000000, 32'h7FFFFFFF});
        add_sample('{20'hFFFFF, 32'h00010000, 32'h00000000});
        add_sample('{20'd0, 32'h00000003, 32'h00000000});
        add_sample('{20'd10486, 32'hFFFF0000, 32'h00010000});
        add_sample('{20'd10487, 32'h00020000, 32'hFFFFFFFF});
        add_sample('{20'd1, 32'h00000000, 32'h00000000});
        run_samples();

        write_reg(REG_P_GAIN, 32'hFFFFFFFF);
        write_reg(REG_I_GAIN, 32'hFFFFFFFF);
        write_reg(REG_D_GAIN, 32'hFFFFFFFF);
        write_reg(REG_FF_GAIN, 32'h80000000);
        write_reg(REG_WINDUP, 32'h0);
        write_reg(REG_STIFFNESS, 32'hFFFFFFFF);
        write_reg(REG_INV_DAMPING, 32'hFFFFFFFF);
        write_reg(REG_MAX_TWIST, 32'h0000FFFF);
        add_sample('{20'd5, 32'h00100000, 32'h00000000});
        add_sample('{20'd0, 32'h00000000, 32'h00100000});
        add_sample('{20'hFFFFF, 32'h7FFFFFFF, 32'h80000000});
        add_sample('{20'd3, 32'h00000001, 32'h00000000});
        run_samples();

        write_reg(REG_P_GAIN, 32'h0);
        write_reg(REG_I_GAIN, 32'h0);
        write_reg(REG_D_GAIN, 32'h0);
        write_reg(REG_FF_GAIN, 32'h7FFFFFFF);
        write_reg(REG_WINDUP, 32'h7FFFFFFF);
        write_reg(REG_STIFFNESS, 32'h0);
        write_reg(REG_INV_DAMPING, 32'h0);
        write_reg(REG_MAX_TWIST, 32'h0);
        add_sample('{20'd50, 32'h00000000, 32'h00050000});
        add_sample('{20'd50, 32'h00000000, 32'hFFFB0000});
        write_reg(REG_MAX_TWIST, 32'd65);
        run_samples();

        for (int phase = 0; phase < 19; phase++) begin
            random_config();
            for (int i = 0; i < 100; i++) begin
                s = rand_sample();
                add_sample(s);
            end
            run_samples();
        end

        if (failures == 0) begin
            $display("pid_admittance_force_axis_unit: match");
        end else begin
            $display("pid_admittance_force_axis_unit: mismatch");
        end
        $finish;
    end

endmodule
